FILE: rtl/h263mv_pkg.sv
// Shared constants, types and a helper function for the H.263 motion vector predictor.
// Depends on nothing; imported by h263_mv_median_predictor.
package h263mv_pkg;

  localparam int MB_COLS    = 64;
  localparam int ROW_SLOTS  = 4;
  localparam int BLK_COLS   = 2 * MB_COLS;
  localparam int BLK_ROWS   = 2 * ROW_SLOTS;

  localparam int MV_W       = 12;
  localparam int MB_COL_W   = 6;
  localparam int MB_ROW_W   = 8;
  localparam int MB_CNT_W   = 9;
  localparam int SLOT_W     = $clog2(ROW_SLOTS);
  localparam int ROW_W      = $clog2(BLK_ROWS);
  localparam int BLK_COL_W  = $clog2(BLK_COLS);
  localparam int ADDR_W     = 1 + ROW_W + BLK_COL_W;
  localparam int MEM_DEPTH  = 2 ** ADDR_W;
  localparam int COL_CALC_W = 11;

  localparam logic [1:0] OP_PREDICT = 2'd0;
  localparam logic [1:0] OP_STORE   = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;

  typedef logic signed [COL_CALC_W-1:0] col_calc_t;

  typedef struct packed {
    logic signed [MV_W-1:0] x;
    logic signed [MV_W-1:0] y;
  } mv_t;

  // Column offset of neighbor C: above-right of the block, above-left for block 3.
  function automatic col_calc_t nb_off(input logic [1:0] blk);
    col_calc_t off;
    case (blk)
      2'd0:    off = col_calc_t'(2);
      2'd1:    off = col_calc_t'(1);
      2'd2:    off = col_calc_t'(1);
      default: off = col_calc_t'(-1);
    endcase
    return off;
  endfunction

endpackage

FILE: rtl/h263_mv_median_predictor.sv
// Top level of the H.263 motion vector median predictor with its vector store.
// Depends on h263mv_pkg for constants, the vector type and the neighbor offset table.
//
// Usage: items arrive on the in_valid/in_ready channel; a predict item yields one
// transfer of pred_x/pred_y on the out_valid/out_ready channel, store and update
// items yield none. The mode register is written through cfg_wr_en/cfg_wr_data.
// All vectors sit in one single-port memory with a registered read, two planes of
// eight block rows by 2*MB_COLS block columns; the border column is decoded in logic.
// The memory port does one access per cycle and sets the rate: a predict item
// does three reads, one optional write and a median step before the next item
// is accepted, and its result is loaded into the output register in the median
// step. A store item does one write, an update item four.
// After reset the block sweeps all MEM_DEPTH = 2048 memory entries to zero, one
// entry per cycle; in_ready stays low during the sweep.
// The output register holds a result while out_ready is low; the next item is
// still accepted, and a later predict waits in its median step until the
// register is free.
module h263_mv_median_predictor
  import h263mv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic                       dir,
  input  logic [MB_COL_W-1:0]        mb_col,
  input  logic [MB_ROW_W-1:0]        mb_row,
  input  logic [1:0]                 block_num,
  input  logic                       first_slice_line,
  input  logic [MB_COL_W-1:0]        resync_col,
  input  logic                       intra,
  input  logic signed [MV_W-1:0]     vec_x,
  input  logic signed [MV_W-1:0]     vec_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [MV_W-1:0]     pred_x,
  output logic signed [MV_W-1:0]     pred_y
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_WR1   = 9'b000000100,
    S_UPD   = 9'b000001000,
    S_RDA   = 9'b000010000,
    S_RDB   = 9'b000100000,
    S_RDC   = 9'b001000000,
    S_ZA    = 9'b010000000,
    S_MED   = 9'b100000000
  } state_t;

  localparam col_calc_t BLK_COLS_S = col_calc_t'(BLK_COLS);

  state_t                 state;
  logic                   h263_pred_mode;
  logic [ADDR_W-1:0]      clr_cnt;
  logic [1:0]             upd_cnt;
  logic                   rd_ok;

  logic                   cur_dir;
  logic [MB_COL_W-1:0]    cur_mbx;
  logic [SLOT_W-1:0]      cur_slot;
  logic [1:0]             cur_blk;
  logic                   cur_fsl;
  logic [MB_COL_W-1:0]    cur_rsx;
  logic                   cur_intra;
  mv_t                    cur_vec;
  logic                   cur_col_ok;

  mv_t                    a_mv;
  mv_t                    b_mv;
  mv_t                    c_mv;
  mv_t                    rdata;
  mv_t                    rd_vec;
  mv_t                    res;
  mv_t                    mem [MEM_DEPTH];

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  mv_t                    mem_wdata;
  logic                   issue_ok;

  logic                   in_xfer;
  logic                   col_ok_in;
  logic                   load_out;
  logic [ROW_W-1:0]       row;
  logic [ROW_W-1:0]       up_row;
  col_calc_t              mbx2;
  col_calc_t              col_b;
  col_calc_t              col_a;
  col_calc_t              col_c;
  col_calc_t              col_upd;
  logic                   a_in;
  logic                   b_in;
  logic                   c_in;
  logic                   zero_a;
  logic                   near_rs;
  logic                   mbx_is_rs;

  function automatic logic signed [MV_W-1:0] med3(input logic signed [MV_W-1:0] a,
                                                  input logic signed [MV_W-1:0] b,
                                                  input logic signed [MV_W-1:0] c);
    logic signed [MV_W-1:0] lo;
    logic signed [MV_W-1:0] hi;
    logic signed [MV_W-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  function automatic mv_t med_mv(input mv_t a, input mv_t b, input mv_t c);
    mv_t r;
    r.x = med3(a.x, b.x, c.x);
    r.y = med3(a.y, b.y, c.y);
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign col_ok_in = ({{(MB_CNT_W-MB_COL_W){1'b0}}, mb_col} < MB_CNT_W'(MB_COLS));

  assign row     = {cur_slot, cur_blk[1]};
  assign up_row  = row - 1'b1;
  assign mbx2    = $signed({{(COL_CALC_W-MB_COL_W-1){1'b0}}, cur_mbx, 1'b0});
  assign col_b   = mbx2 + $signed({{(COL_CALC_W-1){1'b0}}, cur_blk[0]});
  assign col_a   = col_b - col_calc_t'(1);
  assign col_c   = col_b + nb_off(cur_blk);
  assign col_upd = mbx2 + $signed({{(COL_CALC_W-1){1'b0}}, upd_cnt[0]});

  assign a_in = (col_a >= 0) && (col_a < BLK_COLS_S);
  assign b_in = (col_b >= 0) && (col_b < BLK_COLS_S);
  assign c_in = (col_c >= 0) && (col_c < BLK_COLS_S);

  assign mbx_is_rs = (cur_mbx == cur_rsx);
  assign near_rs   = (({1'b0, cur_mbx} + 1'b1) == {1'b0, cur_rsx}) && h263_pred_mode;
  assign zero_a    = cur_fsl && (cur_blk == 2'd2) && mbx_is_rs;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {cur_dir, row, col_a[BLK_COL_W-1:0]};
    mem_wdata = '0;
    issue_ok  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      S_WR1: begin
        mem_we    = cur_col_ok;
        mem_addr  = {cur_dir, row, col_b[BLK_COL_W-1:0]};
        mem_wdata = cur_vec;
      end
      S_UPD: begin
        mem_we    = cur_col_ok;
        mem_addr  = {1'b0, cur_slot, upd_cnt[1], col_upd[BLK_COL_W-1:0]};
        mem_wdata = cur_intra ? '0 : cur_vec;
      end
      S_RDA: begin
        issue_ok = a_in;
      end
      S_RDB: begin
        mem_addr = {cur_dir, up_row, col_b[BLK_COL_W-1:0]};
        issue_ok = b_in;
      end
      S_RDC: begin
        mem_addr = {cur_dir, up_row, col_c[BLK_COL_W-1:0]};
        issue_ok = c_in;
      end
      S_ZA: begin
        mem_we = cur_col_ok && zero_a && a_in;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  assign rd_vec = rd_ok ? rdata : '0;

  always_comb begin
    res = '0;
    if (!cur_col_ok) begin
      res = '0;
    end else if (cur_fsl && (cur_blk == 2'd0)) begin
      if (mbx_is_rs) begin
        res = '0;
      end else if (near_rs) begin
        if (cur_mbx == '0) begin
          res = c_mv;
        end else begin
          res = med_mv(a_mv, '0, c_mv);
        end
      end else begin
        res = a_mv;
      end
    end else if (cur_fsl && (cur_blk == 2'd1)) begin
      res = near_rs ? med_mv(a_mv, '0, c_mv) : a_mv;
    end else begin
      res = med_mv(zero_a ? '0 : a_mv, b_mv, c_mv);
    end
  end

  assign load_out = (state == S_MED) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      upd_cnt        <= '0;
      rd_ok          <= 1'b0;
      out_valid      <= 1'b0;
      h263_pred_mode <= 1'b0;
    end else begin
      rd_ok <= issue_ok;
      if (cfg_wr_en) begin
        h263_pred_mode <= cfg_wr_data;
      end
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            upd_cnt <= '0;
            case (op)
              OP_PREDICT: state <= S_RDA;
              OP_STORE:   state <= S_WR1;
              OP_UPDATE:  state <= S_UPD;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_WR1: state <= S_IDLE;
        S_UPD: begin
          upd_cnt <= upd_cnt + 1'b1;
          if (upd_cnt == 2'd3) begin
            state <= S_IDLE;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: state <= S_RDC;
        S_RDC: state <= S_ZA;
        S_ZA:  state <= S_MED;
        S_MED: begin
          if (load_out) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_dir    <= dir;
      cur_mbx    <= mb_col;
      cur_slot   <= mb_row[SLOT_W-1:0];
      cur_blk    <= block_num;
      cur_fsl    <= first_slice_line;
      cur_rsx    <= resync_col;
      cur_intra  <= intra;
      cur_vec    <= '{x: vec_x, y: vec_y};
      cur_col_ok <= col_ok_in;
    end
    if (state == S_RDB) begin
      a_mv <= rd_vec;
    end
    if (state == S_RDC) begin
      b_mv <= rd_vec;
    end
    if (state == S_ZA) begin
      c_mv <= rd_vec;
    end
    if (load_out) begin
      pred_x <= res.x;
      pred_y <= res.y;
    end
  end

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (mem_we && (mem_wdata == '0)))
    else $error("clearing sweep did not write zero");

  a_reads_no_write: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RDA) || (state == S_RDB) || (state == S_RDC)) |-> !mem_we)
    else $error("memory written during a neighbor read");

  a_store_writes: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (op == OP_STORE) && col_ok_in) |=> mem_we)
    else $error("store transfer was not written in the next cycle");

  a_med_waits: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MED) && out_valid && !out_ready) |=> ((state == S_MED) && out_valid))
    else $error("median step overran a held result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_MED))
    else $error("result appeared outside the median step");

endmodule
